/* rtl/byte_pattern_scanner_unit_assert.svh */
// assertion macros for the byte pattern scanner
`ifndef BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("byte_pattern_scanner_unit: same-cycle check failed");

// next-cycle implication
`define BPS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("byte_pattern_scanner_unit: next-cycle check failed");

`endif

/* rtl/bps_pkg.sv */
`default_nettype none

package bps_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 32;
  localparam int HOLD_W     = 6;
  localparam int PLEN_W     = 6;
  localparam int LEN_W      = 7;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;

  typedef logic [7:0]            byte_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START   = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_PATTERN_WORD_0 = 3'd2,
    CFG_PATTERN_WORD_1 = 3'd3,
    CFG_PATTERN_WORD_2 = 3'd4,
    CFG_PATTERN_WORD_3 = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/bps_ifs.sv */
`default_nettype none

interface bps_byte_if import bps_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bps_match_if import bps_pkg::*; ();
  logic   valid;
  logic   ready;
  addr_t  match_address;
  count_t match_number;

  modport source (output valid, output match_address, output match_number, input ready);
  modport sink   (input valid, input match_address, input match_number, output ready);
endinterface

`default_nettype wire

/* rtl/bps_match.sv */
`default_nettype none

module bps_match import bps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  byte_t             window [PATTERN_MAX],
  input  cfg_word_t         pattern_word [PAT_WORDS],
  input  logic [LEN_W-1:0]  len,
  output logic              window_eq
);

  byte_t                   pat_byte [PAT_BYTES];
  logic [LEN_W-1:0]        pidx     [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]  pos_ok;

  always_comb begin
    for (int b = 0; b < PAT_BYTES; b++) begin
      pat_byte[b] = pattern_word[b / 8][(b % 8) * 8 +: 8];
    end
  end

  // window entry j lines up with pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pidx[j] = len - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) >= len) begin
        pos_ok[j] = 1'b1;
      end else if (pidx[j] >= LEN_W'(PAT_BYTES)) begin
        pos_ok[j] = (window[j] == 8'h00);
      end else begin
        pos_ok[j] = (window[j] == pat_byte[pidx[j][PAT_IDX_W-1:0]]);
      end
    end
  end

  assign window_eq = &pos_ok;

endmodule

`default_nettype wire

/* rtl/byte_pattern_scanner_unit.sv */
// Byte pattern scanner. Takes one region byte per transfer on byte_in and
// reports each leftmost non-overlapping occurrence of the configured pattern
// (1 to 32 bytes, pattern_length) on match_out, with its start address
// (region_start plus the byte offset of the first pattern byte, modulo 2^48)
// and the running match number, which saturates at 2^32-1. A byte flagged
// last_byte ends the region; its own result comes out first and the scan state
// then clears. The result register parts the two sides: the block takes one
// byte every cycle whenever that register is empty or being emptied in the
// same cycle. The whole window compare and the count updates are combinational
// between the window register, with the incoming byte, and the result register,
// and a result appears in the cycle after the byte that completes it.
// Configuration is to be written by the user through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
`default_nettype none

module byte_pattern_scanner_unit import bps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_word_t            cfg_data,
  bps_byte_if.sink             byte_in,
  bps_match_if.source          match_out
);

  addr_t              region_start;
  logic [PLEN_W-1:0]  pattern_length;
  cfg_word_t          pattern_word [PAT_WORDS];

  byte_t              window      [PATTERN_MAX];
  byte_t              window_next [PATTERN_MAX];
  addr_t              byte_offset;
  logic [HOLD_W-1:0]  holdoff;
  count_t             match_count;
  count_t             match_count_next;

  logic               out_valid;
  addr_t              out_address;
  count_t             out_number;

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_m1;
  logic               window_eq;
  logic               hit;
  logic               accept;
  addr_t              address_next;

  assign byte_in.ready = !rst && (!out_valid || match_out.ready);
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    len = {1'b0, pattern_length};
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end
  end

  assign len_m1 = len - LEN_W'(1);

  always_comb begin
    window_next[0] = byte_in.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
  end

  bps_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .window       (window_next),
    .pattern_word (pattern_word),
    .len          (len),
    .window_eq    (window_eq)
  );

  assign hit = ({1'b0, holdoff} >= len_m1) && window_eq;

  assign match_count_next = (match_count == '1) ? match_count
                                                : match_count + CNT_W'(1);
  assign address_next = region_start + byte_offset
                      - {{(ADDR_W-LEN_W){1'b0}}, len_m1};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start   <= '0;
      pattern_length <= PLEN_W'(1);
      for (int w = 0; w < PAT_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_START:   region_start    <= cfg_data[ADDR_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length  <= cfg_data[PLEN_W-1:0];
        CFG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        CFG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        CFG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        CFG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window[j] <= '0;
      end
      byte_offset <= '0;
      holdoff     <= '0;
      match_count <= '0;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
          window[j] <= '0;
        end
        byte_offset <= '0;
        holdoff     <= '0;
        match_count <= '0;
      end else begin
        window      <= window_next;
        byte_offset <= byte_offset + ADDR_W'(1);
        if (hit) begin
          holdoff     <= '0;
          match_count <= match_count_next;
        end else if (holdoff != '1) begin
          holdoff <= holdoff + HOLD_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= hit;
    end else if (match_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      out_address <= address_next;
      out_number  <= match_count_next;
    end
  end

  assign match_out.valid         = out_valid;
  assign match_out.match_address = out_address;
  assign match_out.match_number  = out_number;

endmodule

`default_nettype wire

/* rtl/bps_checker.sv */
`default_nettype none

`include "byte_pattern_scanner_unit_assert.svh"

module bps_checker import bps_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input addr_t  match_address,
  input count_t match_number
);

  // a stalled result holds
  `BPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(match_address) && $stable(match_number))

  // no byte taken while a result is stuck
  `BPS_ASSERT_SAME(a_stall_blocks_in, clk, rst, out_valid && !out_ready, !in_ready)

  // empty result slot means a byte can be taken
  `BPS_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // a result only follows a byte transfer
  `BPS_ASSERT_SAME(a_result_from_byte, clk, rst, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind byte_pattern_scanner_unit bps_checker u_bps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .out_valid     (match_out.valid),
  .out_ready     (match_out.ready),
  .match_address (match_out.match_address),
  .match_number  (match_out.match_number)
);

`default_nettype wire
